// ----- rtl/core/wipr_pkg.sv -----
// ----------------------------------------------------------------------------
// wipr_pkg
// Shared constants and helpers for the wide ID pair renumbering block.
// ----------------------------------------------------------------------------
`default_nettype none

package wipr_pkg;

	localparam int BUCKETS      = 256;
	localparam int KEY_W        = $clog2(BUCKETS);
	localparam int POOL_ENTRIES = 1024;

	localparam logic [15:0] INO_FIRST = 16'd2;
	localparam logic [15:0] INO_UNREP = 16'hFFFF;

	typedef struct packed {
		logic [15:0] dev;
		logic [15:0] ino;
	} short_pair_t;

	// The pair issued after the given last pair.
	function automatic short_pair_t next_pair(input short_pair_t last);
		short_pair_t res;
		logic [15:0] ino_inc;
		ino_inc = last.ino + 16'd1;
		if (ino_inc == INO_UNREP) begin
			res.ino = INO_FIRST;
			res.dev = last.dev + 16'd1;
		end else begin
			res.ino = ino_inc;
			res.dev = last.dev;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/wide_id_pair_renumber_top.sv -----
// ----------------------------------------------------------------------------
// wide_id_pair_renumber_top
// Interns 32-bit device and inode pairs as 16-bit pairs through a chained
// hash table kept in block RAM.
// ----------------------------------------------------------------------------
// The input stream carries one file per item: link count, wide device and
// wide inode. The output stream returns one item per input item with the
// narrow device and inode pair and two flags in tuser.
// Items are taken one at a time. A file with at most one link skips the
// table. A linked file reads its bucket head and then walks the chain,
// since the walk reads one pool entry per cycle from the entry RAM and the
// next address comes from the entry just read.
// A result stays in the output register until taken; the next item is
// accepted meanwhile, and its result waits in the final state while the
// register is still full.
// Reset empties all buckets, restarts the allocator so that the first pair
// issued is device 1, inode 2, and marks the pool as unused. No clearing
// pass is needed. When the pool is full, a new linked file gets inode 65535
// and the table_full flag.
// ----------------------------------------------------------------------------
`default_nettype none

module wide_id_pair_renumber_top #(
	parameter int POOL_ENTRIES = wipr_pkg::POOL_ENTRIES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,  // link_count, long_dev, long_ino
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // short_dev, short_ino
	output logic [1:0]       m_tuser   // reused, table_full
);

	import wipr_pkg::*;

	localparam int IDXW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
	localparam int CNTW = $clog2(POOL_ENTRIES + 1);
	localparam int EW   = 97 + IDXW;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_HEAD = 2'd1;
	localparam logic [1:0] ST_WALK = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]        state_q;
	logic              hit_q;
	logic              linked_q;
	logic [BUCKETS-1:0] head_vld_q;
	logic [CNTW-1:0]   used_q;
	short_pair_t       last_q;

	logic [31:0]       dev_q;
	logic [31:0]       ino_q;
	logic [KEY_W-1:0]  key_q;
	logic [IDXW-1:0]   head_idx_q;
	short_pair_t       pair_q;

	logic              m_tvalid_q;
	logic [31:0]       m_tdata_q;
	logic [1:0]        m_tuser_q;

	logic [KEY_W-1:0]  key_in;
	logic [IDXW-1:0]   head_rdata;
	logic [EW-1:0]     ent_rdata;
	logic [IDXW-1:0]   ent_raddr;
	logic [EW-1:0]     ent_wdata;
	logic              ins_we;
	logic              done_go;
	logic              pool_full;
	logic              match;
	logic [31:0]       e_dev;
	logic [31:0]       e_ino;
	short_pair_t       e_pair;
	logic [IDXW-1:0]   e_link;
	logic              e_lvld;
	short_pair_t       fresh;

	always_comb begin
		key_in    = s_tdata[16 +: KEY_W] ^ s_tdata[48 +: KEY_W];
		e_dev     = ent_rdata[31:0];
		e_ino     = ent_rdata[63:32];
		e_pair    = ent_rdata[95:64];
		e_link    = ent_rdata[96 +: IDXW];
		e_lvld    = ent_rdata[96 + IDXW];
		match     = (e_dev == dev_q) && (e_ino == ino_q);
		ent_raddr = (state_q == ST_HEAD) ? head_rdata : e_link;
		fresh     = next_pair(last_q);
		pool_full = (used_q == CNTW'(POOL_ENTRIES));
		done_go   = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);
		ins_we    = done_go && linked_q && !hit_q && !pool_full;
		ent_wdata = {head_vld_q[key_q], head_idx_q, fresh, ino_q, dev_q};
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	wipr_ram #(
		.WIDTH (IDXW),
		.DEPTH (BUCKETS)
	) u_head_ram (
		.clk   (clk),
		.we    (ins_we),
		.waddr (key_q),
		.wdata (used_q[IDXW-1:0]),
		.raddr (key_in),
		.rdata (head_rdata)
	);

	wipr_ram #(
		.WIDTH (EW),
		.DEPTH (POOL_ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (ins_we),
		.waddr (used_q[IDXW-1:0]),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			hit_q      <= 1'b0;
			linked_q   <= 1'b0;
			head_vld_q <= '0;
			used_q     <= '0;
			last_q     <= '{dev: 16'd1, ino: 16'd1};
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						hit_q    <= 1'b0;
						linked_q <= (s_tdata[15:0] > 16'd1);
						state_q  <= (s_tdata[15:0] > 16'd1) ? ST_HEAD : ST_DONE;
					end
				end
				ST_HEAD: begin
					state_q <= head_vld_q[key_q] ? ST_WALK : ST_DONE;
				end
				ST_WALK: begin
					if (match) begin
						hit_q   <= 1'b1;
						state_q <= ST_DONE;
					end else if (!e_lvld) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (done_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (done_go && !hit_q) begin
				last_q <= fresh;
			end
			if (ins_we) begin
				head_vld_q[key_q] <= 1'b1;
				used_q            <= used_q + CNTW'(1);
			end

			if (done_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			dev_q <= s_tdata[47:16];
			ino_q <= s_tdata[79:48];
			key_q <= key_in;
		end
		if (state_q == ST_HEAD) begin
			head_idx_q <= head_rdata;
		end
		if ((state_q == ST_WALK) && match) begin
			pair_q <= e_pair;
		end
		if (done_go) begin
			if (hit_q) begin
				m_tdata_q <= {pair_q.ino, pair_q.dev};
				m_tuser_q <= 2'b01;
			end else if (linked_q && pool_full) begin
				m_tdata_q <= {INO_UNREP, fresh.dev};
				m_tuser_q <= 2'b10;
			end else begin
				m_tdata_q <= {fresh.ino, fresh.dev};
				m_tuser_q <= 2'b00;
			end
		end
	end

`ifndef SYNTH
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNTW'(POOL_ENTRIES))
		else $error("Pool fill count exceeds the pool size.");

	a_walk_linked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> linked_q)
		else $error("Chain walk started for a file with at most one link.");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("Result is both reused and table full.");

	a_ino_range: assert property (@(posedge clk) disable iff (!arst_n)
		(last_q.ino != INO_UNREP) && (last_q.ino != 16'd0))
		else $error("Allocator inode left its range.");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/wipr_ram.sv -----
// ----------------------------------------------------------------------------
// wipr_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module wipr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- test/tb_wide_id_pair_renumber_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wide_id_pair_renumber_top
// Streams files into the ID pair renumbering block and checks every returned
// item against a predictor that keeps its own allocator and chained table.
// Directed cases come first, then random phases that fill the pool and go
// past it, under varying sender gaps, receiver stalls and a long output
// hold-off.
// ----------------------------------------------------------------------------

module tb_wide_id_pair_renumber_top;
	import wipr_pkg::*;

	localparam int RAND_ITEMS    = 1424;
	localparam int FILL_TARGET   = POOL_ENTRIES + 6;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 200;

	typedef struct {
		logic [15:0] links;
		logic [31:0] wdev;
		logic [31:0] wino;
		int          send_idle;
		int          recv_stall;
		bit          hold;
		bit          drain;
	} file_item_t;

	typedef struct packed {
		logic [15:0] dev;
		logic [15:0] ino;
		logic        reused;
		logic        full;
	} renum_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;

	file_item_t  pending_files[$];
	renum_t      expected_pairs[$];
	bit          known[logic [63:0]];
	logic [63:0] known_list[$];

	bit cur_hold   = 1'b0;
	int cur_stall  = 0;
	int recv_stall = 0;
	int hold_left  = 0;
	int accepted_n = 0;
	int results_n  = 0;
	int fails      = 0;

	short_pair_t last_pair = '{dev: 16'd1, ino: 16'd1};
	bit          head_ok [BUCKETS];
	int          head_idx [BUCKETS];
	logic [31:0] ent_wdev [POOL_ENTRIES];
	logic [31:0] ent_wino [POOL_ENTRIES];
	short_pair_t ent_pair [POOL_ENTRIES];
	bit          ent_next_ok [POOL_ENTRIES];
	int          ent_next [POOL_ENTRIES];
	int          ent_used = 0;

	wide_id_pair_renumber_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	function automatic short_pair_t issue_pair();
		short_pair_t p;
		p = last_pair;
		p.ino = p.ino + 16'd1;
		if (p.ino == INO_UNREP) begin
			p.ino = INO_FIRST;
			p.dev = p.dev + 16'd1;
		end
		last_pair = p;
		return p;
	endfunction

	function automatic renum_t intern_file(input logic [15:0] links, input logic [31:0] wdev,
		input logic [31:0] wino);
		renum_t      r;
		short_pair_t p;
		int          key;
		int          idx;
		int          steps;
		bit          have;
		bit          hit;
		r = '0;
		if (links <= 16'd1) begin
			p = issue_pair();
		end else begin
			key = int'((wdev ^ wino) % BUCKETS);
			have = head_ok[key];
			idx = head_idx[key];
			steps = 0;
			hit = 1'b0;
			while (have && steps < ent_used && idx < POOL_ENTRIES && !hit) begin
				if (ent_wdev[idx] == wdev && ent_wino[idx] == wino) begin
					hit = 1'b1;
				end else begin
					have = ent_next_ok[idx];
					idx = ent_next[idx];
					steps++;
				end
			end
			if (hit) begin
				p = ent_pair[idx];
				r.reused = 1'b1;
			end else begin
				p = issue_pair();
				if (ent_used >= POOL_ENTRIES) begin
					p.ino = INO_UNREP;
					r.full = 1'b1;
				end else begin
					ent_wdev[ent_used] = wdev;
					ent_wino[ent_used] = wino;
					ent_pair[ent_used] = p;
					ent_next_ok[ent_used] = head_ok[key];
					ent_next[ent_used] = head_idx[key];
					head_ok[key] = 1'b1;
					head_idx[key] = ent_used;
					ent_used++;
				end
			end
		end
		r.dev = p.dev;
		r.ino = p.ino;
		return r;
	endfunction

	task automatic add_item(input logic [15:0] links, input logic [31:0] wdev,
		input logic [31:0] wino, input int send_idle, input int recv_pct, input bit hold,
		input bit drain);
		file_item_t f;
		f.links = links;
		f.wdev = wdev;
		f.wino = wino;
		f.send_idle = send_idle;
		f.recv_stall = recv_pct;
		f.hold = hold;
		f.drain = drain;
		pending_files.push_back(f);
		if (links > 16'd1 && !known.exists({wdev, wino})) begin
			known[{wdev, wino}] = 1'b1;
			known_list.push_back({wdev, wino});
		end
	endtask

	// While the pool is filling, most items are new linked pairs; afterwards
	// repeats dominate so that stored pairs hit and unstored ones miss again.
	task automatic add_random_file(input int send_idle, input int recv_pct, input bit hold,
		input bit drain);
		int          pick;
		bit          filling;
		logic [15:0] links;
		logic [63:0] pr;
		logic [31:0] flip;
		filling = known.num() < FILL_TARGET;
		pick = $urandom_range(99);
		pr = {$urandom, $urandom};
		if ($urandom_range(1) == 1) begin
			links = 16'($urandom_range(5, 2));
		end else begin
			links = 16'($urandom_range(65535, 2));
		end
		if (pick < (filling ? 60 : 20)) begin
			links = links;
		end else if (pick < (filling ? 85 : 30)) begin
			if (known_list.size() != 0) begin
				pr = known_list[$urandom_range(known_list.size() - 1)];
				flip = ($urandom | 32'd1) << 8;
				if ($urandom_range(1) == 1) begin
					pr[31:0] = pr[31:0] ^ flip;
				end else begin
					pr[63:32] = pr[63:32] ^ flip;
				end
			end
		end else if (pick < (filling ? 93 : 75)) begin
			if (known_list.size() != 0) begin
				pr = known_list[$urandom_range(known_list.size() - 1)];
			end
		end else begin
			links = 16'($urandom_range(1));
			if ($urandom_range(1) == 1 && known_list.size() != 0) begin
				pr = known_list[$urandom_range(known_list.size() - 1)];
			end
		end
		add_item(links, pr[63:32], pr[31:0], send_idle, recv_pct, hold, drain);
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			fails++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : drive
		file_item_t nxt;
		logic       nxt_valid;
		bit         gate;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			cur_hold <= 1'b0;
			cur_stall <= 0;
			recv_stall <= 0;
			accepted_n <= 0;
		end else begin
			nxt_valid = s_tvalid;
			if (s_tvalid && s_tready) begin
				expected_pairs.push_back(intern_file(s_tdata[15:0], s_tdata[47:16],
					s_tdata[79:48]));
				accepted_n <= accepted_n + 1;
				recv_stall <= cur_stall;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid && pending_files.size() != 0) begin
				gate = !pending_files[0].drain ||
					(!(s_tvalid && s_tready) && accepted_n == results_n);
				if (gate && $urandom_range(99) >= pending_files[0].send_idle) begin
					nxt = pending_files.pop_front();
					s_tdata <= {nxt.wino, nxt.wdev, nxt.links};
					cur_hold <= nxt.hold;
					cur_stall <= nxt.recv_stall;
					nxt_valid = 1'b1;
				end
			end
			s_tvalid <= nxt_valid;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (s_tvalid && s_tready && cur_hold) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin : observe
		renum_t got;
		renum_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			results_n <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata[15:0], m_tdata[31:16], m_tuser[0], m_tuser[1]};
				results_n <= results_n + 1;
				if (expected_pairs.size() == 0) begin
					fails++;
					$display("%0t: unexpected item, expected none, actual %h", $time, got);
				end else begin
					want = expected_pairs.pop_front();
					check_field("short_dev", want.dev, got.dev);
					check_field("short_ino", want.ino, got.ino);
					check_field("reused", 16'(want.reused), 16'(got.reused));
					check_field("table_full", 16'(want.full), 16'(got.full));
				end
			end
			m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall);
		end
	end

	initial begin : stimulus
		int ph;
		int n;
		int sel;
		int send_pct;
		int recv_pct;
		add_item(16'd0, 32'h0000_0000, 32'h0000_0000, 0, 0, 0, 0);
		add_item(16'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0);
		add_item(16'd2, 32'h0000_0000, 32'h0000_0000, 0, 0, 0, 0);
		add_item(16'd2, 32'h0000_0000, 32'h0000_0000, 0, 0, 0, 0);
		add_item(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0);
		add_item(16'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0);
		add_item(16'd1, 32'h0000_0000, 32'h0000_0000, 0, 0, 0, 0);
		add_item(16'd2, 32'h0000_0000, 32'h0000_0100, 0, 0, 0, 0);
		add_item(16'd2, 32'h0000_0100, 32'h0000_0000, 0, 0, 0, 0);
		add_item(16'd2, 32'h0000_0000, 32'h0000_0000, 0, 0, 0, 0);
		add_item(16'd4, 32'h0000_0000, 32'h0000_0100, 0, 0, 0, 0);
		add_item(16'h8000, 32'hAAAA_AAAA, 32'h5555_5555, 0, 0, 0, 0);
		add_item(16'd2, 32'h5555_5555, 32'hAAAA_AAAA, 0, 0, 0, 0);
		add_item(16'h7FFF, 32'hAAAA_AAAA, 32'h5555_5555, 0, 0, 0, 0);
		add_item(16'hFFFF, 32'h1234_5678, 32'h9ABC_DEF0, 0, 0, 0, 0);
		add_item(16'd0, 32'h1234_5678, 32'h9ABC_DEF0, 0, 0, 0, 0);
		for (ph = 0; ph < 8; ph++) begin
			sel = ph % 4;
			send_pct = (sel == 1) ? 51 : (sel == 3) ? 24 : 0;
			recv_pct = (sel == 2) ? 51 : (sel == 3) ? 24 : 0;
			for (n = 0; n < RAND_ITEMS / 8; n++) begin
				add_random_file(send_pct, recv_pct, sel == 0 && n == 5, n == 0);
			end
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_files.size() != 0 || s_tvalid || accepted_n != results_n) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_pairs.size() != 0) begin
			fails += expected_pairs.size();
			$display("%0t: %0d expected items never arrived", $time, expected_pairs.size());
		end
		if (fails == 0) begin
			$display("tb_wide_id_pair_renumber_top passed");
		end else begin
			$display("tb_wide_id_pair_renumber_top failed");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("tb_wide_id_pair_renumber_top failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/wipr_pkg.sv
rtl/core/wipr_ram.sv
rtl/core/wide_id_pair_renumber_top.sv
test/tb_wide_id_pair_renumber_top.sv
